### sv/bba_pkg.sv
package bba_pkg;

    localparam int MAP_ENTRIES_DEF = 64;

    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAP_SIZE = REG_IDX_W'(0);
    localparam logic [COUNT_W-1:0]   MAP_SIZE_RST = COUNT_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

endpackage

### sv/bba_if.sv
interface bba_req_if;
    logic                          valid;
    logic                          ready;
    bba_pkg::t_req                 req_type;
    logic [bba_pkg::INDEX_W-1:0]   free_index;

    modport source (output valid, req_type, free_index, input ready);
    modport sink   (input valid, req_type, free_index, output ready);
endinterface

interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    bba_pkg::t_status              status;
    logic [bba_pkg::INDEX_W-1:0]   granted_index;
    logic [bba_pkg::COUNT_W-1:0]   free_entries;

    modport source (output valid, status, granted_index, free_entries, input ready);
    modport sink   (input valid, status, granted_index, free_entries, output ready);
endinterface

### sv/bba_cell.sv
module bba_cell #(
    parameter int  MAP_ENTRIES = bba_pkg::MAP_ENTRIES_DEF,
    parameter int  CELL_IDX    = 0,
    parameter type t_wave      = logic,
    localparam int IDX_W       = $clog2(MAP_ENTRIES),
    localparam int CNT_W       = $clog2(MAP_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_wave                       i_wave,
    output t_wave                       o_wave,
    input  logic [CNT_W-1:0]            i_size,
    input  logic [CNT_W-1:0]            i_hint,
    input  logic [bba_pkg::INDEX_W-1:0] i_idx,
    input  logic                        i_wr_en,
    input  logic [IDX_W-1:0]            i_wr_idx,
    input  logic                        i_wr_used
);

    localparam logic [CNT_W-1:0] K_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] K_IDX = IDX_W'(CELL_IDX);

    logic  r_used;
    t_wave r_wave;
    t_wave n_wave;
    logic  free_here;

    assign free_here = (K_CNT < i_size) && !r_used;

    // keep the two lowest free positions seen so far, plus a running count and the used bits at the hint and the index
    always_comb begin
        n_wave = i_wave;
        if (free_here) begin
            if (!i_wave.f1) begin
                n_wave.f1 = 1'b1;
                n_wave.i1 = K_IDX;
            end else if (!i_wave.f2) begin
                n_wave.f2 = 1'b1;
                n_wave.i2 = K_IDX;
            end
        end
        n_wave.cnt = i_wave.cnt + CNT_W'(free_here);
        if (i_hint == K_CNT) begin
            n_wave.hint_used = r_used;
        end
        if (int'(i_idx) == CELL_IDX) begin
            n_wave.idx_used = r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_wr_en && (i_wr_idx == K_IDX)) begin
            r_used <= i_wr_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.vld <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

### sv/bitmap_block_allocator_unit.sv
// Bitmap allocator over MAP_ENTRIES entries, of which map_size (saturated to
// 1..MAP_ENTRIES) are in use. Allocate grants the hinted entry, or the lowest
// free one when the hint is stale, then points the hint at the lowest free
// entry; free clears an entry and points the hint at it. Each response carries
// the free count after the request. The used bits live in a row of cells, one
// bit per cell; a scan wave walks the row one cell per cycle collecting the
// two lowest free entries, the free count and the bits at the hint and at the
// free index. A new request is accepted only once the current one has been
// scanned and finished; finishing waits until the output register is free.
// A finished response waits in an output register while the next request is
// already scanned. map_size is written over the APB port at address 0 and
// should only change while no request is in flight.
module bitmap_block_allocator_unit #(
    parameter int MAP_ENTRIES = bba_pkg::MAP_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bba_req_if.sink                       i_req,
    bba_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W     = $clog2(MAP_ENTRIES);
    localparam int CNT_W     = $clog2(MAP_ENTRIES + 1);
    localparam int OUT_IDX_W = bba_pkg::INDEX_W;
    localparam int OUT_CNT_W = bba_pkg::COUNT_W;
    localparam int PDATA_W   = bba_pkg::PDATA_W;

    typedef struct packed {
        logic             vld;
        logic             f1;
        logic [IDX_W-1:0] i1;
        logic             f2;
        logic [IDX_W-1:0] i2;
        logic [CNT_W-1:0] cnt;
        logic             hint_used;
        logic             idx_used;
    } t_wave;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // configuration
    logic [OUT_CNT_W-1:0] r_map_size;
    logic                 cfg_wr;
    logic                 cfg_hit;
    logic [CNT_W-1:0]     size;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[bba_pkg::PADDR_W-1:2] == bba_pkg::REG_MAP_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= bba_pkg::MAP_SIZE_RST;
        end else if (cfg_wr && cfg_hit) begin
            r_map_size <= pwdata[OUT_CNT_W-1:0];
        end
    end

    assign prdata = cfg_hit ? PDATA_W'(r_map_size) : '0;

    always_comb begin
        if (r_map_size == '0) begin
            size = CNT_W'(1);
        end else if (int'(r_map_size) > MAP_ENTRIES) begin
            size = CNT_W'(MAP_ENTRIES);
        end else begin
            size = CNT_W'(r_map_size);
        end
    end

    // control
    t_state                     r_state;
    logic                       r_launch;
    bba_pkg::t_req              r_req_type;
    logic [OUT_IDX_W-1:0]       r_idx;
    logic [CNT_W-1:0]           r_hint;
    t_wave                      r_tail;
    logic                       r_out_vld;
    bba_pkg::t_status           r_status;
    logic [OUT_IDX_W-1:0]       r_granted;
    logic [OUT_CNT_W-1:0]       r_free;

    t_wave                      w_chain [MAP_ENTRIES+1];
    logic                       req_acc;
    logic                       fin_go;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign fin_go      = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);

    always_comb begin
        w_chain[0]           = '0;
        w_chain[0].vld       = r_launch;
    end

    // finalize from the scan summary
    logic                       hint_ok;
    logic                       can_grant;
    logic                       idx_ok;
    logic [IDX_W-1:0]           grant;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic                       wr_used;
    bba_pkg::t_status           n_status;
    logic [OUT_IDX_W-1:0]       n_granted;
    logic [CNT_W-1:0]           n_free;
    logic [CNT_W-1:0]           n_hint;

    assign hint_ok   = (r_hint < size) && !r_tail.hint_used;
    assign can_grant = hint_ok || r_tail.f1;
    assign grant     = hint_ok ? IDX_W'(r_hint) : r_tail.i1;
    assign idx_ok    = (32'(r_idx) < 32'(size));

    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = grant;
        wr_used   = 1'b1;
        n_status  = bba_pkg::ST_OK;
        n_granted = '0;
        n_free    = r_tail.cnt;
        n_hint    = r_hint;
        case (r_req_type)
            bba_pkg::REQ_ALLOC: begin
                if (can_grant) begin
                    wr_en     = fin_go;
                    n_granted = OUT_IDX_W'(grant);
                    n_free    = r_tail.cnt - CNT_W'(1);
                    // granted the lowest free entry: the next one becomes lowest
                    if (grant == r_tail.i1) begin
                        n_hint = r_tail.f2 ? CNT_W'(r_tail.i2) : size;
                    end else begin
                        n_hint = CNT_W'(r_tail.i1);
                    end
                end else begin
                    n_status = bba_pkg::ST_FULL;
                    n_hint   = size;
                end
            end
            bba_pkg::REQ_FREE: begin
                if (idx_ok) begin
                    wr_en   = fin_go;
                    wr_idx  = IDX_W'(r_idx);
                    wr_used = 1'b0;
                    n_hint  = CNT_W'(r_idx);
                    n_free  = r_tail.cnt + CNT_W'(r_tail.idx_used);
                end else begin
                    n_status = bba_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = bba_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_hint    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_launch <= req_acc;
            if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_chain[MAP_ENTRIES].vld) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state   <= S_IDLE;
                        r_hint    <= n_hint;
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req_type <= i_req.req_type;
            r_idx      <= i_req.free_index;
        end
        if ((r_state == S_SCAN) && w_chain[MAP_ENTRIES].vld) begin
            r_tail <= w_chain[MAP_ENTRIES];
        end
        if (fin_go) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_free    <= OUT_CNT_W'(n_free);
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.free_entries  = r_free;

    // cell row
    for (genvar k = 0; k < MAP_ENTRIES; k++) begin : g_cell
        bba_cell #(
            .MAP_ENTRIES (MAP_ENTRIES),
            .CELL_IDX    (k),
            .t_wave      (t_wave)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wave    (w_chain[k]),
            .o_wave    (w_chain[k+1]),
            .i_size    (size),
            .i_hint    (r_hint),
            .i_idx     (r_idx),
            .i_wr_en   (wr_en),
            .i_wr_idx  (wr_idx),
            .i_wr_used (wr_used)
        );
    end

endmodule
